[design/cke_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cke_pkg
// Shared constants, result type and tag tables for the certificate key
// field extractor.
// ----------------------------------------------------------------------------
package cke_pkg;

	localparam int MAX_CERT_BYTES = 4096;
	localparam int BC_W           = $clog2(MAX_CERT_BYTES + 1);

	// configuration register indexes
	localparam logic REG_KEY_KIND = 1'b0;

	// header stages
	localparam logic [1:0] STG_TAG  = 2'd0;
	localparam logic [1:0] STG_LEN0 = 2'd1;
	localparam logic [1:0] STG_LENX = 2'd2;
	localparam logic [1:0] STG_BODY = 2'd3;

	// status codes
	localparam logic [4:0] ST_OK    = 5'd0;
	localparam logic [4:0] ST_TRUNC = 5'd16;
	localparam logic [4:0] ST_EMPTY = 5'd17;

	// extraction kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SPKI = 2'd1;
	localparam logic [1:0] KIND_PRIV = 2'd2;
	localparam logic [1:0] KIND_SEQ  = 2'd3;

	// field indexes
	localparam logic [3:0] PH_OUTER  = 4'd0;
	localparam logic [3:0] PH_TBS    = 4'd1;
	localparam logic [3:0] PH_VER    = 4'd2;
	localparam logic [3:0] PH_SERIAL = 4'd3;
	localparam logic [3:0] PH_SPKI   = 4'd8;
	localparam logic [3:0] PH_KEYSEQ = 4'd9;
	localparam logic [3:0] PH_KEY    = 4'd10;
	localparam logic [3:0] PH_DEVID  = 4'd11;
	localparam logic [3:0] PH_ALGC   = 4'd12;
	localparam logic [3:0] PH_KVER   = 4'd13;
	localparam logic [3:0] PH_CKEY   = 4'd14;

	// DER bytes
	localparam logic [7:0] TAG_SEQ  = 8'h30;
	localparam logic [7:0] LEN_ONE  = 8'h81;
	localparam logic [7:0] LEN_TWO  = 8'h82;
	localparam logic [7:0] TAG_CTX0 = 8'ha0;
	localparam logic [7:0] TAG_INT  = 8'h02;
	localparam logic [7:0] TAG_CTX2 = 8'ha2;
	localparam logic [7:0] TAG_BITS = 8'h03;

	localparam logic [15:0] FIXED_LEN = 16'd14;
	localparam logic [15:0] FIXED_SKIP = 16'd2;

	typedef struct packed {
		logic [7:0]  key_byte;
		logic        is_last;
		logic [4:0]  status;
		logic [15:0] key_length;
	} res_t;

	function automatic logic [7:0] expected_tag(input logic [3:0] phase, input logic [1:0] mode);
		logic [7:0] t;
		case (phase)
			PH_VER:    t = TAG_CTX0;
			PH_SERIAL: t = TAG_INT;
			PH_KEY:    t = (mode == KIND_PRIV) ? LEN_ONE : TAG_CTX2;
			PH_DEVID:  t = TAG_BITS;
			PH_ALGC:   t = TAG_BITS;
			PH_KVER:   t = TAG_INT;
			PH_CKEY:   t = TAG_BITS;
			default:   t = TAG_SEQ;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] final_phase(input logic [1:0] mode);
		logic [3:0] p;
		case (mode)
			KIND_PRIV: p = PH_KEY;
			KIND_SEQ:  p = PH_CKEY;
			default:   p = PH_SPKI;
		endcase
		return p;
	endfunction

endpackage

[design/cke_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cke_cfg
// APB register slave holding the key_kind selection.
// ----------------------------------------------------------------------------
module cke_cfg import cke_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [1:0]  key_kind
);

	logic [1:0] key_kind_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_KEY_KIND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_kind_q <= KIND_SPKI;
		end else if (wr_en) begin
			key_kind_q <= pwdata[1:0];
		end
	end

	assign prdata   = (paddr[2] == REG_KEY_KIND) ? {30'd0, key_kind_q} : 32'd0;
	assign key_kind = key_kind_q;

endmodule

[design/cke_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cke_parser
// DER walk state and combinational step: tag check, length header decode,
// skip/copy counting and result formation for one certificate byte.
// ----------------------------------------------------------------------------
module cke_parser import cke_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] cert_byte,
	input  logic       cert_last,
	input  logic [1:0] key_kind,
	output logic       res_valid,
	output res_t       res
);

	logic [3:0]      phase_q, phase_d;
	logic [1:0]      stage_q, stage_d;
	logic [1:0]      hdr_q, hdr_d;
	logic [15:0]     fl_q, fl_d;
	logic [15:0]     skip_q, skip_d;
	logic [15:0]     emitted_q, emitted_d;
	logic            fin_q, fin_d;
	logic [BC_W-1:0] bc_q, bc_d;
	logic [1:0]      mode_q, mode_d;

	always_comb begin
		logic [1:0]      m;
		logic [BC_W-1:0] bc_inc;
		logic            spki;
		logic [4:0]      st;
		logic            emit;
		logic            done;
		logic            sb_go;
		logic [15:0]     sb_len;
		logic [15:0]     flv;

		phase_d   = phase_q;
		stage_d   = stage_q;
		hdr_d     = hdr_q;
		fl_d      = fl_q;
		skip_d    = skip_q;
		emitted_d = emitted_q;
		fin_d     = fin_q;
		bc_d      = bc_q;
		mode_d    = mode_q;
		res_valid = 1'b0;
		res       = '0;
		st        = ST_OK;
		emit      = 1'b0;
		done      = 1'b0;
		sb_go     = 1'b0;
		sb_len    = '0;
		flv       = '0;
		m         = (bc_q == '0) ? ((key_kind == KIND_NONE) ? KIND_SPKI : key_kind) : mode_q;
		bc_inc    = bc_q + BC_W'(1);
		spki      = (phase_q == PH_SPKI) && (m == KIND_SPKI);

		if (!fin_q) begin
			mode_d = m;
			bc_d   = bc_inc;
			case (stage_q)
				STG_TAG: begin
					if (cert_byte != expected_tag(phase_q, m)) begin
						st = 5'(phase_q) + 5'd1;
					end else begin
						emit = spki;
						if (phase_q == PH_DEVID || phase_q == PH_ALGC) begin
							stage_d = STG_BODY;
							skip_d  = FIXED_SKIP;
							fl_d    = FIXED_LEN;
						end else begin
							stage_d = STG_LEN0;
						end
					end
				end
				STG_LEN0: begin
					emit = spki;
					if (cert_byte == LEN_ONE || cert_byte == LEN_TWO) begin
						hdr_d   = (cert_byte == LEN_ONE) ? 2'd1 : 2'd2;
						fl_d    = '0;
						stage_d = STG_LENX;
					end else begin
						sb_go  = 1'b1;
						sb_len = {8'd0, cert_byte};
					end
				end
				STG_LENX: begin
					emit  = spki;
					flv   = {fl_q[7:0], cert_byte};
					hdr_d = hdr_q - 2'd1;
					if (hdr_d == 2'd0) begin
						sb_go  = 1'b1;
						sb_len = flv;
					end else begin
						fl_d = flv;
					end
				end
				default: begin
					if (skip_q != '0) begin
						skip_d = skip_q - 16'd1;
					end else if (fl_q != '0) begin
						emit = 1'b1;
						fl_d = fl_q - 16'd1;
					end
				end
			endcase

			if (sb_go) begin
				stage_d = STG_BODY;
				skip_d  = '0;
				fl_d    = '0;
				if (phase_q == PH_OUTER || phase_q == PH_TBS || phase_q == PH_KEYSEQ
						|| (phase_q == PH_KEY && m == KIND_SEQ)) begin
					fl_d = '0;
				end else if ((phase_q == PH_SPKI && m == KIND_SPKI) || phase_q == PH_KVER) begin
					fl_d = sb_len;
				end else if (phase_q == PH_KEY || phase_q == PH_CKEY) begin
					if (sb_len == '0) begin
						st = ST_EMPTY;
					end else begin
						skip_d = 16'd1;
						fl_d   = sb_len - 16'd1;
					end
				end else begin
					skip_d = sb_len;
				end
			end

			if (st == ST_OK && stage_d == STG_BODY && skip_d == '0 && fl_d == '0) begin
				if (phase_q == final_phase(m)) begin
					done = 1'b1;
				end else begin
					phase_d = phase_q + 4'd1;
					stage_d = STG_TAG;
				end
			end

			if (st != ST_OK) begin
				res_valid = 1'b1;
				res       = '{key_byte: 8'd0, is_last: 1'b1, status: st, key_length: emitted_q};
			end else if (done) begin
				emitted_d = emitted_q + {15'd0, emit};
				res_valid = 1'b1;
				res       = '{key_byte: emit ? cert_byte : 8'd0, is_last: 1'b1,
				              status: ST_OK, key_length: emitted_d};
			end else if (cert_last || bc_inc >= BC_W'(MAX_CERT_BYTES)) begin
				res_valid = 1'b1;
				res       = '{key_byte: 8'd0, is_last: 1'b1, status: ST_TRUNC,
				              key_length: emitted_q};
			end else if (emit) begin
				emitted_d = emitted_q + 16'd1;
				res_valid = 1'b1;
				res       = '{key_byte: cert_byte, is_last: 1'b0, status: ST_OK,
				              key_length: 16'd0};
			end
			if (res_valid && res.is_last) begin
				fin_d = 1'b1;
			end
		end

		// restart on end of certificate once finished
		if ((fin_q || (res_valid && res.is_last)) && cert_last) begin
			phase_d   = PH_OUTER;
			stage_d   = STG_TAG;
			hdr_d     = '0;
			fl_d      = '0;
			skip_d    = '0;
			emitted_d = '0;
			fin_d     = 1'b0;
			bc_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OUTER;
			stage_q   <= STG_TAG;
			hdr_q     <= '0;
			fl_q      <= '0;
			skip_q    <= '0;
			emitted_q <= '0;
			fin_q     <= 1'b0;
			bc_q      <= '0;
			mode_q    <= KIND_SPKI;
		end else if (accept) begin
			phase_q   <= phase_d;
			stage_q   <= stage_d;
			hdr_q     <= hdr_d;
			fl_q      <= fl_d;
			skip_q    <= skip_d;
			emitted_q <= emitted_d;
			fin_q     <= fin_d;
			bc_q      <= bc_d;
			mode_q    <= mode_d;
		end
	end

endmodule

[design/cke_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cke_out_buf
// Two-entry result register; decouples input acceptance from output stalls.
// ----------------------------------------------------------------------------
module cke_out_buf import cke_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic space,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign space     = (cnt_q != 2'd2);
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[design/cert_key_field_extractor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cert_key_field_extractor_top
// Streams a DER certificate in one byte per transaction and streams out the
// selected key field, closed by one status transaction (tlast high).
// ----------------------------------------------------------------------------
// One certificate byte is taken per clock; each byte is handled in one step
// (tag compare, length decode, counter update) and its result, if any,
// lands in a two-entry output register, so input stalls only when both entries
// are held by a stalled master side. key_kind is sampled at the first byte of
// each certificate; after the closing transaction, bytes up to tlast are
// dropped. Write key_kind only while no certificate is in flight.
module cert_key_field_extractor_top import cke_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] cert_byte
	input  logic        s_tlast,  // cert_last
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] key_byte, [12:8] status, [28:13] key_length
	output logic        m_tlast   // is_last
);

	logic [1:0] key_kind;
	logic       accept;
	logic       res_valid;
	res_t       res;
	res_t       out_res;

	assign accept = s_tvalid && s_tready;

	cke_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key_kind (key_kind)
	);

	cke_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cert_byte (s_tdata),
		.cert_last (s_tlast),
		.key_kind  (key_kind),
		.res_valid (res_valid),
		.res       (res)
	);

	cke_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.space     (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {3'd0, out_res.key_length, out_res.status, out_res.key_byte};
	assign m_tlast = out_res.is_last;

endmodule

[design/cke_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cke_checker
// Port-level checks on the extractor output stream, bound to the top level.
// ----------------------------------------------------------------------------
module cke_checker import cke_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// key byte transactions carry ok status and zero length
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[12:8] == ST_OK && m_tdata[28:13] == 16'd0)
		else $error("non-final transaction with status or length");

	// any error closes the certificate
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12:8] != ST_OK |-> m_tlast && m_tdata[7:0] == 8'd0)
		else $error("error status without closing transaction");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:29] == 3'd0)
		else $error("tdata padding not zero");

	// input is only held off while results are waiting
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |-> m_tvalid)
		else $error("input refused with no result pending");

endmodule

bind cert_key_field_extractor_top cke_checker u_cke_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[sim/tb_cert_key_field_extractor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cert_key_field_extractor_top
// Streams DER certificates into the extractor one byte per transaction and
// compares every output transaction with a cycle-free model of the parser.
// A short directed set is followed by phases of random certificates (mostly
// well formed, some truncated, corrupted or pure noise) under each key_kind
// setting, with random backpressure and source gaps.
// ----------------------------------------------------------------------------
module tb_cert_key_field_extractor_top;
	import cke_pkg::*;

	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 250;
	localparam int MAX_REPORTS    = 200;
	// key_kind per random phase, phase 0 in the low bits
	localparam logic [15:0] KIND_PLAN = {KIND_SEQ, KIND_SPKI, KIND_PRIV, KIND_SEQ,
		KIND_SPKI, KIND_NONE, KIND_SEQ, KIND_PRIV};
	// minimal certificate: long headers on the outer levels, one-byte SPKI body
	localparam logic [175:0] MIN_CERT =
		176'h30_82_ff_ff_30_81_90_a0_00_02_00_30_00_30_00_30_00_30_00_30_01_ff;

	typedef struct packed {
		logic [7:0] cbyte;
		logic       clast;
	} cert_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;  // [7:0] cert_byte
	logic        s_tlast = 1'b0; // cert_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [7:0] key_byte, [12:8] status, [28:13] key_length
	logic        m_tlast;       // is_last

	cert_key_field_extractor_top dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [7:0]  cert_buf[$];
	cert_item_t  pend_q[$];
	res_t        key_q[$];
	cert_item_t  tx_item;
	int          bytes_pending = 0;
	int          err_count = 0;
	int          idle_level = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          stall_cycles = 0;
	bit          s_taken = 1'b0;

	// parser model state
	logic [1:0]  kind_reg = KIND_SPKI;
	logic [1:0]  cur_kind = KIND_SPKI;
	logic [3:0]  phase = PH_OUTER;
	logic [1:0]  stage = STG_TAG;
	logic [1:0]  hdr_left = '0;
	logic [15:0] copy_left = '0;
	logic [15:0] skip_left = '0;
	logic [15:0] n_emitted = '0;
	bit          finished = 1'b0;
	int unsigned n_bytes = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	function automatic logic [7:0] der_tag_for(input logic [3:0] ph, input logic [1:0] k);
		if (ph == PH_VER) return TAG_CTX0;
		if (ph == PH_SERIAL || ph == PH_KVER) return TAG_INT;
		if (ph == PH_DEVID || ph == PH_ALGC || ph == PH_CKEY) return TAG_BITS;
		if (ph == PH_KEY) return (k == KIND_PRIV) ? LEN_ONE : TAG_CTX2;
		return TAG_SEQ;
	endfunction

	task automatic restart_parse();
		phase = PH_OUTER;
		stage = STG_TAG;
		hdr_left = '0;
		copy_left = '0;
		skip_left = '0;
		n_emitted = '0;
		finished = 1'b0;
		n_bytes = 0;
	endtask

	// field body set-up once its length is known
	function automatic logic [4:0] open_body(input logic [15:0] len);
		stage = STG_BODY;
		skip_left = '0;
		copy_left = '0;
		if (phase == PH_OUTER || phase == PH_TBS || phase == PH_KEYSEQ ||
				(phase == PH_KEY && cur_kind == KIND_SEQ))
			return ST_OK;
		if ((phase == PH_SPKI && cur_kind == KIND_SPKI) || phase == PH_KVER) begin
			copy_left = len;
			return ST_OK;
		end
		if (phase == PH_KEY || phase == PH_CKEY) begin
			if (len == 0) return ST_EMPTY;
			skip_left = 16'd1;
			copy_left = len - 16'd1;
			return ST_OK;
		end
		skip_left = len;
		return ST_OK;
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic lst);
		logic [4:0] st;
		logic [3:0] end_phase;
		bit         emit;
		bit         done;
		bit         spki;
		res_t       r;
		st = ST_OK;
		emit = 1'b0;
		done = 1'b0;
		if (finished) begin
			if (lst) restart_parse();
			return;
		end
		if (n_bytes == 0) cur_kind = (kind_reg == KIND_NONE) ? KIND_SPKI : kind_reg;
		n_bytes++;
		spki = (phase == PH_SPKI && cur_kind == KIND_SPKI);
		case (stage)
			STG_TAG: begin
				if (b != der_tag_for(phase, cur_kind)) begin
					st = {1'b0, phase} + 5'd1;
				end else begin
					emit = spki;
					if (phase == PH_DEVID || phase == PH_ALGC) begin
						stage = STG_BODY;
						skip_left = FIXED_SKIP;
						copy_left = FIXED_LEN;
					end else begin
						stage = STG_LEN0;
					end
				end
			end
			STG_LEN0: begin
				emit = spki;
				if (b == LEN_ONE || b == LEN_TWO) begin
					hdr_left = (b == LEN_ONE) ? 2'd1 : 2'd2;
					copy_left = '0;
					stage = STG_LENX;
				end else begin
					st = open_body({8'h00, b});
				end
			end
			STG_LENX: begin
				emit = spki;
				copy_left = {copy_left[7:0], b};
				hdr_left = hdr_left - 2'd1;
				if (hdr_left == 0) st = open_body(copy_left);
			end
			default: begin
				if (skip_left > 0) begin
					skip_left--;
				end else if (copy_left > 0) begin
					emit = 1'b1;
					copy_left--;
				end
			end
		endcase

		end_phase = (cur_kind == KIND_PRIV) ? PH_KEY : (cur_kind == KIND_SEQ) ? PH_CKEY : PH_SPKI;
		if (st == ST_OK && stage == STG_BODY && skip_left == 0 && copy_left == 0) begin
			if (phase == end_phase) begin
				done = 1'b1;
			end else begin
				phase = phase + 4'd1;
				stage = STG_TAG;
			end
		end

		if (st != ST_OK) begin
			r = {8'h00, 1'b1, st, n_emitted};
		end else if (done) begin
			if (emit) n_emitted++;
			r = {emit ? b : 8'h00, 1'b1, ST_OK, n_emitted};
		end else if (lst || n_bytes >= MAX_CERT_BYTES) begin
			r = {8'h00, 1'b1, ST_TRUNC, n_emitted};
		end else if (emit) begin
			n_emitted++;
			r = {b, 1'b0, ST_OK, 16'h0000};
			key_q.push_back(r);
			return;
		end else begin
			return;
		end
		key_q.push_back(r);
		finished = 1'b1;
		if (lst) restart_parse();
	endtask

	task automatic check_result();
		res_t want;
		if (key_q.size() == 0) begin
			report("result with none expected", m_tdata, 32'h0);
			return;
		end
		want = key_q.pop_front();
		if (m_tdata[7:0] !== want.key_byte)
			report("key_byte", 32'(m_tdata[7:0]), 32'(want.key_byte));
		if (m_tlast !== want.is_last) report("is_last", 32'(m_tlast), 32'(want.is_last));
		if (m_tdata[12:8] !== want.status)
			report("status", 32'(m_tdata[12:8]), 32'(want.status));
		if (m_tdata[28:13] !== want.key_length)
			report("key_length", 32'(m_tdata[28:13]), 32'(want.key_length));
	endtask

	// monitor: everything sampled at the rising edge
	always @(posedge clk) begin
		s_taken = s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) check_result();
			if (s_taken) begin
				bytes_pending--;
				predict_byte(s_tdata, s_tlast);
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == {REG_KEY_KIND, 2'b00}) kind_reg = pwdata[1:0];
				end else if (prdata !== {30'd0, kind_reg}) begin
					report("key_kind readback", prdata, {30'd0, kind_reg});
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic bit go_idle();
		case (idle_level)
			0: return 1'b0;
			1: return $urandom_range(0, 15) == 0;
			default: return $urandom_range(0, 3) == 0;
		endcase
	endfunction

	// source side
	always @(negedge clk) begin
		if (!s_tvalid || s_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (go_idle()) begin
				tx_gap = $urandom_range(0, 9);
				s_tvalid <= 1'b0;
			end else if (pend_q.size() != 0) begin
				tx_item = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= tx_item.cbyte;
				s_tlast <= tx_item.clast;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side
	always @(negedge clk) begin
		if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (go_idle()) begin
			rx_gap = $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic apb_xfer(input logic wr, input logic [31:0] wdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_KEY_KIND, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		while (bytes_pending != 0 || key_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic ship_cert();
		cert_item_t it;
		foreach (cert_buf[i]) begin
			it.cbyte = cert_buf[i];
			it.clast = (i == cert_buf.size() - 1);
			pend_q.push_back(it);
		end
		bytes_pending += cert_buf.size();
		cert_buf.delete();
	endtask

	function automatic int unsigned rand_len();
		int unsigned pick;
		pick = $urandom_range(0, 39);
		if (pick == 0) return $urandom_range(128, 300);
		if (pick <= 6) return 0;
		return $urandom_range(1, 6);
	endfunction

	// tag, length header in a random legal form, then optional random body
	task automatic put_field(input logic [7:0] tag, input int unsigned len, input bit with_body);
		int unsigned form;
		logic [15:0] l16;
		l16 = 16'(len);
		form = $urandom_range(0, 2);
		if (len > 255) form = 2;
		else if (form == 0 && (l16[7:0] == LEN_ONE || l16[7:0] == LEN_TWO)) form = 1;
		cert_buf.push_back(tag);
		case (form)
			0: cert_buf.push_back(l16[7:0]);
			1: begin
				cert_buf.push_back(LEN_ONE);
				cert_buf.push_back(l16[7:0]);
			end
			default: begin
				cert_buf.push_back(LEN_TWO);
				cert_buf.push_back(l16[15:8]);
				cert_buf.push_back(l16[7:0]);
			end
		endcase
		if (with_body) repeat (len) cert_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_cert(input logic [1:0] k);
		cert_buf.delete();
		put_field(TAG_SEQ, $urandom_range(0, 65535), 1'b0);
		put_field(TAG_SEQ, $urandom_range(0, 65535), 1'b0);
		put_field(TAG_CTX0, rand_len(), 1'b1);
		put_field(TAG_INT, rand_len(), 1'b1);
		repeat (5) put_field(TAG_SEQ, rand_len(), 1'b1);
		if (k == KIND_PRIV) begin
			put_field(TAG_SEQ, $urandom_range(0, 65535), 1'b0);
			put_field(LEN_ONE, rand_len(), 1'b1);
		end else if (k == KIND_SEQ) begin
			put_field(TAG_SEQ, $urandom_range(0, 65535), 1'b0);
			put_field(TAG_CTX2, $urandom_range(0, 65535), 1'b0);
			repeat (2) begin
				cert_buf.push_back(TAG_BITS);
				repeat (FIXED_SKIP + FIXED_LEN) cert_buf.push_back(8'($urandom_range(0, 255)));
			end
			put_field(TAG_INT, rand_len(), 1'b1);
			put_field(TAG_BITS, rand_len(), 1'b1);
		end
		repeat ($urandom_range(0, 3)) cert_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin
		int unsigned phase_bytes;
		int unsigned pick;
		int unsigned cut;
		logic [1:0]  k;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_xfer(1'b0, 32'h0);
		// tag mismatch on the first byte, then a dropped byte closing the certificate
		cert_buf.push_back(8'h00);
		cert_buf.push_back(8'hff);
		ship_cert();
		// certificate cut after its first byte
		cert_buf.push_back(TAG_SEQ);
		ship_cert();
		for (int i = 21; i >= 0; i--) cert_buf.push_back(MIN_CERT[8*i +: 8]);
		ship_cert();
		settle();

		for (int p = 0; p < 8; p++) begin
			k = KIND_PLAN[2*p +: 2];
			idle_level = (p == 7) ? 0 : $urandom_range(0, 2);
			apb_xfer(1'b1, {30'd0, k});
			apb_xfer(1'b0, 32'h0);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					repeat ($urandom_range(1, 30)) cert_buf.push_back(8'($urandom_range(0, 255)));
				end else begin
					build_cert(k);
					if (pick < 20) begin
						cut = $urandom_range(1, cert_buf.size());
						while (cert_buf.size() > cut) cert_buf.delete(cert_buf.size() - 1);
					end else if (pick < 32) begin
						cert_buf[$urandom_range(0, cert_buf.size() - 1)] =
							8'($urandom_range(0, 255));
					end
				end
				phase_bytes += cert_buf.size();
				ship_cert();
			end
			settle();
		end

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
